// ===== hw/rtl/incremental_pid_controller_macros.svh =====
// ----------------------------------------------------------------------------
// incremental pid controller assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_CONTROLLER_MACROS_SVH
`define INCREMENTAL_PID_CONTROLLER_MACROS_SVH

// same-cycle implication
`define IPID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ipid_pkg.sv =====
// ----------------------------------------------------------------------------
// ipid_pkg
// widths, register indexes and reset values of the incremental pid controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipid_pkg;

  localparam int IPID_FIELD_W   = 32;
  localparam int IPID_BAND_W    = 31;
  localparam int IPID_CFG_IDX_W = 3;

  localparam int IPID_DATA_WIDTH_DEF = 32;
  localparam int IPID_FRAC_BITS_DEF  = 16;

  localparam logic signed [IPID_FIELD_W-1:0] IPID_MAX_OUT_RST = 32'sh7FFF_FFFF;
  localparam logic signed [IPID_FIELD_W-1:0] IPID_MIN_OUT_RST = 32'sh8000_0000;

  typedef enum logic [IPID_CFG_IDX_W-1:0] {
    CFG_KP      = 3'd0,
    CFG_KI      = 3'd1,
    CFG_KD      = 3'd2,
    CFG_I_BAND  = 3'd3,
    CFG_D_BAND  = 3'd4,
    CFG_MAX_OUT = 3'd5,
    CFG_MIN_OUT = 3'd6
  } ipid_cfg_idx_t;

endpackage

// ===== hw/rtl/ipid_in_if.sv =====
// ----------------------------------------------------------------------------
// ipid_in_if
// sample channel: setpoint and feedback word with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipid_in_if import ipid_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [IPID_FIELD_W-1:0] setpoint;
  logic signed [IPID_FIELD_W-1:0] feedback;

  modport source (output valid, output setpoint, output feedback, input ready);
  modport sink   (input valid, input setpoint, input feedback, output ready);
endinterface

// ===== hw/rtl/ipid_out_if.sv =====
// ----------------------------------------------------------------------------
// ipid_out_if
// result channel: drive word and clamp flag with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipid_out_if import ipid_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [IPID_FIELD_W-1:0] drive;
  logic                           clamped;

  modport source (output valid, output drive, output clamped, input ready);
  modport sink   (input valid, input drive, input clamped, output ready);
endinterface

// ===== hw/rtl/incremental_pid_controller.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_controller
// velocity-form pid with integral and derivative separation, q16.16 words
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake     word
//   in_chan   in    valid/ready   setpoint, feedback
//   out_chan  out   valid/ready   drive, clamped
//   cfg_*     in    cfg_we        cfg_idx, cfg_wdata
//
// one word accepted per cycle while the result slot is empty or being taken; a word
// passes the stage 1, stage 2 and result registers before its result is valid
// the rate is set by the drive recurrence, closed inside the final stage
// three stages advance together; a stalled result holds every stage
// no clearing pass: state registers are reset directly by the synchronous rst_n
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module incremental_pid_controller import ipid_pkg::*; #(
  parameter int DATA_WIDTH = IPID_DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = IPID_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ipid_in_if.sink                   in_chan,
  ipid_out_if.source                out_chan,
  input  logic                      cfg_we,
  input  logic [IPID_CFG_IDX_W-1:0] cfg_idx,
  input  logic [IPID_FIELD_W-1:0]   cfg_wdata
);

  `include "incremental_pid_controller_macros.svh"

  // saturation width of every intermediate
  localparam int SATW   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  // wide enough for a sum of four saturated terms
  localparam int SUM_W  = 34;
  // gain times saturated value, exact
  localparam int PROD_W = IPID_FIELD_W + SATW;

  localparam logic signed [SUM_W-1:0]  SAT_MAX_S = (SUM_W'(1) <<< (SATW - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0]  SAT_MIN_S = -SAT_MAX_S - SUM_W'(1);
  localparam logic signed [PROD_W-1:0] SAT_MAX_P = (PROD_W'(1) <<< (SATW - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SAT_MIN_P = -SAT_MAX_P - PROD_W'(1);

  function automatic logic signed [SATW-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic signed [SATW-1:0] r;
    if (v > SAT_MAX_S) begin
      r = SAT_MAX_S[SATW-1:0];
    end else if (v < SAT_MIN_S) begin
      r = SAT_MIN_S[SATW-1:0];
    end else begin
      r = v[SATW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SATW-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
    logic signed [SATW-1:0] r;
    if (v > SAT_MAX_P) begin
      r = SAT_MAX_P[SATW-1:0];
    end else if (v < SAT_MIN_P) begin
      r = SAT_MIN_P[SATW-1:0];
    end else begin
      r = v[SATW-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [IPID_FIELD_W-1:0] kp_r, ki_r, kd_r;
  logic signed [IPID_FIELD_W-1:0] max_out_r, min_out_r;
  logic        [IPID_BAND_W-1:0]  i_band_r, d_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r      <= '0;
      ki_r      <= '0;
      kd_r      <= '0;
      i_band_r  <= '0;
      d_band_r  <= '0;
      max_out_r <= IPID_MAX_OUT_RST;
      min_out_r <= IPID_MIN_OUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_KP:      kp_r      <= cfg_wdata;
        CFG_KI:      ki_r      <= cfg_wdata;
        CFG_KD:      kd_r      <= cfg_wdata;
        CFG_I_BAND:  i_band_r  <= cfg_wdata[IPID_BAND_W-1:0];
        CFG_D_BAND:  d_band_r  <= cfg_wdata[IPID_BAND_W-1:0];
        CFG_MAX_OUT: max_out_r <= cfg_wdata;
        CFG_MIN_OUT: min_out_r <= cfg_wdata;
        default: ; // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: all stages move together when the result slot frees
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, out_valid_r;
  logic adv, in_fire, out_fire;

  assign adv      = !out_valid_r || out_chan.ready;
  assign in_fire  = in_chan.valid && adv;
  assign out_fire = out_valid_r && out_chan.ready;

  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_fire;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: error, first and second differences, band gates
  // prev_error_r / prev_delta_r double as the stage 1 error and difference
  // --------------------------------------------------------------------------
  logic signed [SATW-1:0]  prev_error_r, prev_delta_r;
  logic signed [SATW-1:0]  dde_s1_r;
  logic                    i_en_s1_r, d_en_s1_r;

  logic signed [SUM_W-1:0] diff_w, de_w, dde_w;
  logic signed [SATW-1:0]  err_c, de_c, dde_c;
  logic signed [SATW:0]    err_x;
  logic        [SATW:0]    mag_c;
  logic                    i_en_c, d_en_c;

  always_comb begin
    diff_w = SUM_W'(in_chan.setpoint) - SUM_W'(in_chan.feedback);
    err_c  = sat_sum(diff_w);
    de_w   = SUM_W'(err_c) - SUM_W'(prev_error_r);
    de_c   = sat_sum(de_w);
    dde_w  = SUM_W'(de_c) - SUM_W'(prev_delta_r);
    dde_c  = sat_sum(dde_w);
    // magnitude needs one more bit for the most negative error
    err_x  = (SATW + 1)'(err_c);
    mag_c  = err_x[SATW] ? unsigned'(-err_x) : unsigned'(err_x);
  end

  // bands are compared at full width so that a narrow datapath keeps the test
  logic [IPID_FIELD_W:0] mag_w;
  assign mag_w  = (IPID_FIELD_W + 1)'(mag_c);
  assign i_en_c = (i_band_r == '0) || (mag_w < (IPID_FIELD_W + 1)'(i_band_r));
  assign d_en_c = (d_band_r == '0) || (mag_w < (IPID_FIELD_W + 1)'(d_band_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
      prev_delta_r <= '0;
    end else if (in_fire) begin
      prev_error_r <= err_c;
      prev_delta_r <= de_c;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dde_s1_r  <= dde_c;
      i_en_s1_r <= i_en_c;
      d_en_s1_r <= d_en_c;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: the three gain products, floor shift, saturate, gate
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] p_prod, i_prod, d_prod;
  logic signed [SATW-1:0]   p_c, i_c, d_c;
  logic signed [SATW-1:0]   p_s2_r, i_s2_r, d_s2_r;

  always_comb begin
    p_prod = PROD_W'(kp_r) * PROD_W'(prev_delta_r);
    i_prod = PROD_W'(ki_r) * PROD_W'(prev_error_r);
    d_prod = PROD_W'(kd_r) * PROD_W'(dde_s1_r);
    // arithmetic shift floors toward minus infinity
    p_c = sat_prod(p_prod >>> FRAC_BITS);
    i_c = i_en_s1_r ? sat_prod(i_prod >>> FRAC_BITS) : '0;
    d_c = d_en_s1_r ? sat_prod(d_prod >>> FRAC_BITS) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv && v1_r) begin
      p_s2_r <= p_c;
      i_s2_r <= i_c;
      d_s2_r <= d_c;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: accumulate onto the previous drive, saturate, clamp
  // drive_r is also the stored previous drive, hence its reset
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0]        sum_w;
  logic signed [SATW-1:0]         sum_sat;
  logic signed [IPID_FIELD_W-1:0] lim_c;
  logic                           hit_c;
  logic signed [IPID_FIELD_W-1:0] drive_r;
  logic                           clamped_r;

  always_comb begin
    sum_w   = SUM_W'(drive_r) + SUM_W'(p_s2_r) + SUM_W'(i_s2_r) + SUM_W'(d_s2_r);
    sum_sat = sat_sum(sum_w);
    lim_c   = IPID_FIELD_W'(sum_sat);
    hit_c   = 1'b0;
    // upper limit first, then lower: lower wins when the limits cross
    if (lim_c > max_out_r) begin
      lim_c = max_out_r;
      hit_c = 1'b1;
    end
    if (lim_c < min_out_r) begin
      lim_c = min_out_r;
      hit_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r   <= '0;
      clamped_r <= 1'b0;
    end else if (adv && v2_r) begin
      drive_r   <= lim_c;
      clamped_r <= hit_c;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.drive   = drive_r;
  assign out_chan.clamped = clamped_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `IPID_ASSERT_NEXT(a_accept_fills_s1, in_fire, v1_r, "accepted word missing from stage 1")
  `IPID_ASSERT_NEXT(a_s1_moves_on, v1_r && adv, v2_r, "stage 1 word lost on advance")
  `IPID_ASSERT_NEXT(a_s2_to_result, v2_r && adv, out_valid_r, "stage 2 word lost before result")
  `IPID_ASSERT_NEXT(a_result_drains, out_fire && !v2_r, !out_valid_r, "result repeated")

endmodule
